// ----- rtl/i2c_slave_flash_loader_top_macros.svh -----
// ----------------------------------------------------------------------------
// i2c slave flash loader assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_FLASH_LOADER_TOP_MACROS_SVH
`define I2C_SLAVE_FLASH_LOADER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfl: implication check failed");

// next-cycle implication, off during reset
`define SFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfl: next-cycle check failed");

`endif

// ----- rtl/sfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg
// types, bus event codes and command characters of the flash loader
// ----------------------------------------------------------------------------
package sfl_pkg;

  // bus event codes
  localparam logic [3:0] MODE_NONE     = 4'd0;
  localparam logic [3:0] MODE_ADDR_WR  = 4'd1;
  localparam logic [3:0] MODE_BYTE_ACK = 4'd2;
  localparam logic [3:0] MODE_BYTE_NAK = 4'd3;
  localparam logic [3:0] MODE_STOP     = 4'd4;
  localparam logic [3:0] MODE_ADDR_RD  = 4'd5;
  localparam logic [3:0] MODE_SENT_ACK = 4'd6;
  localparam logic [3:0] MODE_TX_END   = 4'd7;
  localparam logic [3:0] MODE_BUS_ERR  = 4'd8;

  // bus reply kinds
  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_ACK  = 2'd1;
  localparam logic [1:0] RK_NACK = 2'd2;
  localparam logic [1:0] RK_STOP = 2'd3;

  // flash operations
  localparam logic [1:0] FOP_NONE  = 2'd0;
  localparam logic [1:0] FOP_FILL  = 2'd1;
  localparam logic [1:0] FOP_WRITE = 2'd2;
  localparam logic [1:0] FOP_BOOT  = 2'd3;

  // command and reply characters
  localparam logic [7:0] CH_QUERY    = 8'h3F; // '?'
  localparam logic [7:0] CH_SYNC     = 8'h21; // '!'
  localparam logic [7:0] CH_FILL     = 8'h66; // 'f'
  localparam logic [7:0] CH_FILL_RSP = 8'h46; // 'F'
  localparam logic [7:0] CH_WRITE    = 8'h77; // 'w'
  localparam logic [7:0] CH_WR_RSP   = 8'h57; // 'W'
  localparam logic [7:0] CH_BOOT     = 8'h62; // 'b'

  // fixed bytes ahead of the payload: command, address high, address low, length
  localparam int HDR_BYTES = 1 + 2 + 1;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  flash_op;
    logic [15:0] flash_address;
    logic [15:0] flash_word;
    logic        last;
  } sfl_result_t;

  function automatic sfl_result_t sfl_reply(input logic [1:0] kind);
    sfl_result_t r;
    r = '0;
    r.reply_kind = kind;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic sfl_result_t sfl_flash(input logic [1:0] op,
                                            input logic [15:0] addr,
                                            input logic [15:0] word);
    sfl_result_t r;
    r = '0;
    r.flash_op      = op;
    r.flash_address = addr;
    r.flash_word    = word;
    return r;
  endfunction

endpackage

// ----- rtl/sfl_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl channel interfaces
// bus event channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfl_in_if;
  import sfl_pkg::*;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface sfl_out_if;
  import sfl_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [1:0]  flash_op;
  logic [15:0] flash_address;
  logic [15:0] flash_word;
  logic        last;

  modport source (output valid, output reply_kind, output tx_valid, output tx_byte,
                  output flash_op, output flash_address, output flash_word,
                  output last, input ready);
  modport sink   (input valid, input reply_kind, input tx_valid, input tx_byte,
                  input flash_op, input flash_address, input flash_word,
                  input last, output ready);
endinterface

// ----- rtl/sfl_rx_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_rx_mem
// receive byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sfl_rx_mem #(
  parameter int STORE_SIZE = 36,
  parameter int IDX_W      = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  logic [7:0]            mem [STORE_SIZE];
  logic [STORE_SIZE-1:0] vld_r;
  logic [7:0]            rdq_r;
  logic                  hit_r;
  logic [AW-1:0]         wa;
  logic [AW-1:0]         ra;
  logic                  in_range;

  assign wa       = wr_idx[AW-1:0];
  assign ra       = rd_idx[AW-1:0];
  assign in_range = (32'(rd_idx) < STORE_SIZE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    if (rd_en) begin
      rdq_r <= mem[ra];
    end
  end

  // never-written entries read as zero, as do indexes past the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= in_range && vld_r[ra];
      end
    end
  end

  assign rd_data = rdq_r & {8{hit_r}};
endmodule

// ----- rtl/sfl_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_engine
// event decoder and stop-time command sequencer around the receive store
// ----------------------------------------------------------------------------
module sfl_engine #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_mode,
  input  logic [7:0]           in_data,
  input  logic                 can_load,
  output logic                 res_load,
  output sfl_pkg::sfl_result_t res
);
  import sfl_pkg::*;

  localparam int STORE_SIZE = HDR_BYTES + PAYLOAD_BYTES;
  localparam int IDX_W      = $clog2(STORE_SIZE + 1);
  localparam int CNT_W      = $clog2(PAYLOAD_BYTES + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CMD  = 4'd1;
  localparam logic [3:0] S_AH   = 4'd2;
  localparam logic [3:0] S_AL   = 4'd3;
  localparam logic [3:0] S_LEN  = 4'd4;
  localparam logic [3:0] S_LO   = 4'd5;
  localparam logic [3:0] S_HI   = 4'd6;
  localparam logic [3:0] S_FOUT = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] rx_pos_r, rx_pos_nxt;
  logic [7:0]       reply0_r, reply0_nxt;
  logic [7:0]       reply1_r, reply1_nxt;
  logic [5:0]       rpos_r, rpos_nxt;
  logic [1:0]       rlen_r, rlen_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [15:0]      word_r, word_nxt;
  sfl_result_t      pend_r, pend_nxt;

  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  logic [CNT_W-1:0] i_step;
  logic [CNT_W-1:0] lim_new;
  logic [5:0]       rpos_inc;
  logic [7:0]       tx_b;
  sfl_result_t      tx_res;

  sfl_rx_mem #(
    .STORE_SIZE(STORE_SIZE),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (mem_we),
    .wr_idx (rx_pos_r),
    .wr_data(in_data),
    .rd_en  (mem_re),
    .rd_idx (rd_idx),
    .rd_data(rd_data)
  );

  assign i_step   = i_r + CNT_W'(2);
  assign lim_new  = (32'(rd_data) < PAYLOAD_BYTES) ? CNT_W'(rd_data)
                                                   : CNT_W'(PAYLOAD_BYTES);
  assign rpos_inc = (rpos_r != 6'd63) ? rpos_r + 6'd1 : rpos_r;
  assign tx_b     = (rpos_r == 6'd0) ? reply0_r :
                    (rpos_r == 6'd1) ? reply1_r : 8'd0;

  always_comb begin
    tx_res          = sfl_reply((rpos_inc < 6'(rlen_r)) ? RK_ACK : RK_NACK);
    tx_res.tx_valid = 1'b1;
    tx_res.tx_byte  = tx_b;
  end

  always_comb begin
    state_nxt  = state_r;
    rx_pos_nxt = rx_pos_r;
    reply0_nxt = reply0_r;
    reply1_nxt = reply1_r;
    rpos_nxt   = rpos_r;
    rlen_nxt   = rlen_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    lim_nxt    = lim_r;
    i_nxt      = i_r;
    lo_nxt     = lo_r;
    word_nxt   = word_r;
    pend_nxt   = pend_r;
    in_ready   = (state_r == S_IDLE);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_idx     = '0;
    res        = pend_r;
    res_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_ADDR_WR: begin
              rx_pos_nxt = '0;
              pend_nxt   = sfl_reply(RK_ACK);
              state_nxt  = S_EMIT;
            end
            MODE_BYTE_ACK: begin
              // bytes past the store are dropped
              if (32'(rx_pos_r) < STORE_SIZE) begin
                mem_we     = 1'b1;
                rx_pos_nxt = rx_pos_r + IDX_W'(1);
              end
              pend_nxt  = sfl_reply(RK_ACK);
              state_nxt = S_EMIT;
            end
            MODE_BYTE_NAK: begin
              pend_nxt  = sfl_reply(RK_NACK);
              state_nxt = S_EMIT;
            end
            MODE_STOP: begin
              rpos_nxt  = '0;
              mem_re    = 1'b1;
              rd_idx    = IDX_W'(0);
              state_nxt = S_CMD;
            end
            MODE_ADDR_RD, MODE_SENT_ACK: begin
              rpos_nxt  = rpos_inc;
              pend_nxt  = tx_res;
              state_nxt = S_EMIT;
            end
            MODE_TX_END: begin
              pend_nxt  = sfl_reply(RK_ACK);
              state_nxt = S_EMIT;
            end
            MODE_BUS_ERR: begin
              pend_nxt  = sfl_reply(RK_STOP);
              state_nxt = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CMD: begin
        cmd_nxt   = rd_data;
        mem_re    = 1'b1;
        rd_idx    = IDX_W'(1);
        state_nxt = S_AH;
      end
      S_AH: begin
        addr_nxt[15:8] = rd_data;
        mem_re         = 1'b1;
        rd_idx         = IDX_W'(2);
        state_nxt      = S_AL;
      end
      S_AL: begin
        addr_nxt[7:0] = rd_data;
        mem_re        = 1'b1;
        rd_idx        = IDX_W'(3);
        state_nxt     = S_LEN;
      end
      S_LEN: begin
        len_nxt  = rd_data;
        lim_nxt  = lim_new;
        i_nxt    = '0;
        pend_nxt = sfl_reply(RK_ACK);
        unique case (cmd_r)
          CH_QUERY: begin
            reply0_nxt = CH_SYNC;
            rlen_nxt   = 2'd1;
            state_nxt  = S_EMIT;
          end
          CH_FILL: begin
            if (lim_new != '0) begin
              mem_re    = 1'b1;
              rd_idx    = IDX_W'(HDR_BYTES);
              state_nxt = S_LO;
            end else begin
              reply0_nxt = CH_FILL_RSP;
              reply1_nxt = rd_data;
              rlen_nxt   = 2'd2;
              state_nxt  = S_EMIT;
            end
          end
          CH_WRITE: begin
            reply0_nxt = CH_WR_RSP;
            reply1_nxt = 8'd1;
            rlen_nxt   = 2'd2;
            pend_nxt   = sfl_flash(FOP_WRITE, addr_r, 16'd0);
            state_nxt  = S_EMIT;
          end
          CH_BOOT: begin
            pend_nxt  = sfl_flash(FOP_BOOT, 16'd0, 16'd0);
            state_nxt = S_EMIT;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_LO: begin
        lo_nxt    = rd_data;
        mem_re    = 1'b1;
        rd_idx    = IDX_W'(HDR_BYTES + 1) + IDX_W'(i_r);
        state_nxt = S_HI;
      end
      S_HI: begin
        word_nxt  = {rd_data, lo_r};
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        res = sfl_flash(FOP_FILL, addr_r + 16'(i_r), word_r);
        if (can_load) begin
          res_load = 1'b1;
          i_nxt    = i_step;
          if (i_step < lim_r) begin
            mem_re    = 1'b1;
            rd_idx    = IDX_W'(HDR_BYTES) + IDX_W'(i_step);
            state_nxt = S_LO;
          end else begin
            reply0_nxt = CH_FILL_RSP;
            reply1_nxt = len_r;
            rlen_nxt   = 2'd2;
            pend_nxt   = sfl_reply(RK_ACK);
            state_nxt  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (can_load) begin
          res_load = 1'b1;
          if (pend_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            // a flash result held here is always followed by the acknowledge
            pend_nxt = sfl_reply(RK_ACK);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rx_pos_r <= '0;
      reply0_r <= '0;
      reply1_r <= '0;
      rpos_r   <= '0;
      rlen_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rx_pos_r <= rx_pos_nxt;
      reply0_r <= reply0_nxt;
      reply1_r <= reply1_nxt;
      rpos_r   <= rpos_nxt;
      rlen_r   <= rlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
    lim_r  <= lim_nxt;
    i_r    <= i_nxt;
    lo_r   <= lo_nxt;
    word_r <= word_nxt;
    pend_r <= pend_nxt;
  end
endmodule

// ----- rtl/i2c_slave_flash_loader_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_flash_loader_top
// i2c slave command engine that feeds flash fill, write and boot operations
// ----------------------------------------------------------------------------
// usage:
//  - in_ch carries one bus event word per handshake: mode and data_byte
//  - out_ch carries result words: bus reply, transmit byte, flash operation;
//    last marks the final word of one event, always the bus reply
//  - most events give one word; it is registered as pending, loaded into
//    the output register from S_EMIT, and then the next event is taken
//  - a stop reads the four header bytes from the receive store one by one,
//    then a fill command reads the low and high byte of each fill word
//    (S_LO, S_HI) and hands the word out from S_FOUT; the single read port
//    of the store is why the bytes are read one at a time
//  - undefined modes and mode none give no word and return to idle at once
//  - reset clears the control state, the reply and the store's valid bits
//    directly, so there is no clearing pass
//  - a stalled receiver holds the output register; the sequencer waits on
//    it and takes no new event until the current one is fully handed over,
//    but a new event is accepted while the final word still waits
// ----------------------------------------------------------------------------
module i2c_slave_flash_loader_top #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sfl_in_if.sink    in_ch,
  sfl_out_if.source out_ch
);
  import sfl_pkg::*;

  logic        can_load;
  logic        res_load;
  sfl_result_t res;

  // output register
  logic        out_valid_r;
  sfl_result_t out_data_r;

  // the engine may load when the slot is empty or being emptied
  assign can_load = !out_valid_r || out_ch.ready;

  sfl_engine #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_mode  (in_ch.mode),
    .in_data  (in_ch.data_byte),
    .can_load (can_load),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reply_kind    = out_data_r.reply_kind;
  assign out_ch.tx_valid      = out_data_r.tx_valid;
  assign out_ch.tx_byte       = out_data_r.tx_byte;
  assign out_ch.flash_op      = out_data_r.flash_op;
  assign out_ch.flash_address = out_data_r.flash_address;
  assign out_ch.flash_word    = out_data_r.flash_word;
  assign out_ch.last          = out_data_r.last;
endmodule

// ----- rtl/sfl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_checker
// port-level checks on the result channel of the flash loader
// ----------------------------------------------------------------------------
`include "i2c_slave_flash_loader_top_macros.svh"

module sfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  reply_kind,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic [1:0]  flash_op,
  input logic        last
);
  import sfl_pkg::*;

  // a stalled word stays put
  `SFL_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(flash_op) && $stable(last))

  // the transmit byte reads zero whenever tx_valid is low
  `SFL_ASSERT_IMP(a_tx_zero, clk, rst_n, out_valid && !tx_valid, tx_byte == 8'd0)

  // flash words carry no bus reply and never close an event
  `SFL_ASSERT_IMP(a_flash, clk, rst_n, out_valid && (flash_op != FOP_NONE), !last && (reply_kind == RK_NONE) && !tx_valid)

  // every closing word is a bus reply without a flash operation
  `SFL_ASSERT_IMP(a_last, clk, rst_n, out_valid && last, (flash_op == FOP_NONE) && (reply_kind != RK_NONE))
endmodule

bind i2c_slave_flash_loader_top sfl_checker u_sfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .reply_kind(out_ch.reply_kind),
  .tx_valid  (out_ch.tx_valid),
  .tx_byte   (out_ch.tx_byte),
  .flash_op  (out_ch.flash_op),
  .last      (out_ch.last)
);
